>>> rtl/core/cdq_pkg.sv
// Shared types, constants and index helpers for the circular deque.
// Used by cdq_cell, cdq_ctrl, circular_deque and cdq_checker; depends on nothing.
package cdq_pkg;

   localparam int DEPTH  = 16;
   localparam int IDX_W  = $clog2(DEPTH);
   localparam int WORD_W = 32;
   localparam int OCC_W  = $clog2(DEPTH + 1);
   localparam int CMD_W  = 3;

   typedef logic [IDX_W-1:0]  idx_type;
   typedef logic [WORD_W-1:0] word_type;
   typedef logic [OCC_W-1:0]  cnt_type;
   typedef logic [CMD_W-1:0]  cmd_type;

   localparam cnt_type CAP_RESET = OCC_W'(DEPTH);

   localparam cmd_type CMD_PUSH_FRONT = 3'd0;
   localparam cmd_type CMD_PUSH_REAR  = 3'd1;
   localparam cmd_type CMD_POP_FRONT  = 3'd2;
   localparam cmd_type CMD_POP_REAR   = 3'd3;

   typedef enum logic [1:0] {
      STAT_DONE  = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_EMPTY = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   // Control broadcast from the sequencer to every cell of the row.
   typedef struct packed {
      logic     write_en;
      idx_type  write_idx;
      word_type write_data;
      idx_type  front_idx;
      idx_type  rear_idx;
   } cell_ctl_type;

   // Next index toward the rear, wrapping at the usable capacity.
   function automatic idx_type step_up(idx_type idx, cnt_type cap);
      cnt_type nxt;
      nxt = OCC_W'(idx) + OCC_W'(1);
      if (nxt >= cap) begin
         return '0;
      end
      return nxt[IDX_W-1:0];
   endfunction

   // Next index toward the front; an index beyond the capacity also wraps.
   function automatic idx_type step_down(idx_type idx, cnt_type cap);
      cnt_type prv;
      cnt_type ext;
      ext = OCC_W'(idx);
      prv = cap - OCC_W'(1);
      if (idx == '0 || ext >= cap) begin
         return prv[IDX_W-1:0];
      end
      return idx - IDX_W'(1);
   endfunction

endpackage

>>> rtl/core/cdq_cell.sv
// One slot of the deque storage plus its stage of the front and rear readout chains.
// Depends on cdq_pkg.
module cdq_cell (
   input  logic                  clock,
   input  cdq_pkg::idx_type      cell_idx,
   input  cdq_pkg::cell_ctl_type ctl,
   input  cdq_pkg::word_type     up_front,
   input  cdq_pkg::word_type     up_rear,
   output cdq_pkg::word_type     down_front,
   output cdq_pkg::word_type     down_rear
);
   import cdq_pkg::*;

   word_type slot_ff;
   word_type front_pass_ff;
   word_type rear_pass_ff;

   always_ff @(posedge clock) begin
      if (ctl.write_en && ctl.write_idx == cell_idx) begin
         slot_ff <= ctl.write_data;
      end
      // The selected cell injects its slot; every other cell passes its neighbor's word on.
      front_pass_ff <= (ctl.front_idx == cell_idx) ? slot_ff : up_front;
      rear_pass_ff  <= (ctl.rear_idx == cell_idx) ? slot_ff : up_rear;
   end

   assign down_front = front_pass_ff;
   assign down_rear  = rear_pass_ff;

endmodule

>>> rtl/core/cdq_ctrl.sv
// Command sequencer of the deque: indices, occupancy, capacity register and status.
// Depends on cdq_pkg; drives the cell row through a cell_ctl_type bundle.
module cdq_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  cdq_pkg::cmd_type      req_command,
   input  cdq_pkg::word_type     req_data_value,
   input  logic                  csr_we,
   input  cdq_pkg::cnt_type      csr_wdata,
   output cdq_pkg::cell_ctl_type ctl,
   input  cdq_pkg::word_type     chain_front,
   input  cdq_pkg::word_type     chain_rear,
   output logic                  rsp_valid,
   output logic [1:0]            rsp_status,
   output logic                  rsp_is_empty,
   output cdq_pkg::cnt_type      rsp_occupancy,
   output cdq_pkg::word_type     rsp_front_value,
   output cdq_pkg::word_type     rsp_rear_value
);
   import cdq_pkg::*;

   state_type  state_ff, state_in;
   idx_type    front_ff, front_in;
   idx_type    rear_ff, rear_in;
   cnt_type    count_ff, count_in;
   cnt_type    cap_ff;
   status_type status_ff, status_in;
   idx_type    scan_ff, scan_in;
   cnt_type    cap_eff;
   logic       accept;
   logic       scan_last;
   logic       wr_en;
   idx_type    wr_idx;

   assign accept    = start && !busy;
   assign scan_last = (scan_ff == IDX_W'(DEPTH - 1));

   always_comb begin
      if (cap_ff == '0) begin
         cap_eff = OCC_W'(1);
      end else if (cap_ff > OCC_W'(DEPTH)) begin
         cap_eff = OCC_W'(DEPTH);
      end else begin
         cap_eff = cap_ff;
      end
   end

   // Command datapath: new indices, occupancy, status and the slot write.
   always_comb begin
      front_in  = front_ff;
      rear_in   = rear_ff;
      count_in  = count_ff;
      status_in = status_ff;
      wr_en     = 1'b0;
      wr_idx    = '0;
      if (accept) begin
         status_in = STAT_DONE;
         case (req_command) inside
            CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
               if (count_ff >= cap_eff) begin
                  status_in = STAT_FULL;
               end else begin
                  wr_en    = 1'b1;
                  count_in = count_ff + OCC_W'(1);
                  if (count_ff == '0) begin
                     front_in = '0;
                     rear_in  = '0;
                     wr_idx   = '0;
                  end else if (req_command == CMD_PUSH_FRONT) begin
                     front_in = step_down(front_ff, cap_eff);
                     wr_idx   = front_in;
                  end else begin
                     rear_in = step_up(rear_ff, cap_eff);
                     wr_idx  = rear_in;
                  end
               end
            end
            CMD_POP_FRONT, CMD_POP_REAR: begin
               if (count_ff == '0) begin
                  status_in = STAT_EMPTY;
               end else begin
                  count_in = count_ff - OCC_W'(1);
                  if (count_ff == OCC_W'(1)) begin
                     front_in = '0;
                     rear_in  = '0;
                  end else if (req_command == CMD_POP_FRONT) begin
                     front_in = step_up(front_ff, cap_eff);
                  end else begin
                     rear_in = step_down(rear_ff, cap_eff);
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (state_ff)
         ST_IDLE: state_in = accept ? ST_SCAN : ST_IDLE;
         ST_SCAN: state_in = scan_last ? ST_DONE : ST_SCAN;
         ST_DONE: state_in = accept ? ST_SCAN : ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      scan_in = '0;
      if (state_ff == ST_SCAN && !scan_last) begin
         scan_in = scan_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         front_ff  <= '0;
         rear_ff   <= '0;
         count_ff  <= '0;
         cap_ff    <= CAP_RESET;
         status_ff <= STAT_DONE;
         scan_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         front_ff  <= front_in;
         rear_ff   <= rear_in;
         count_ff  <= count_in;
         status_ff <= status_in;
         scan_ff   <= scan_in;
         if (csr_we) begin
            cap_ff <= csr_wdata;
         end
      end
   end

   always_comb begin
      busy            = (state_ff == ST_SCAN);
      rsp_valid       = (state_ff == ST_DONE);
      rsp_status      = status_ff;
      rsp_is_empty    = (count_ff == '0);
      rsp_occupancy   = count_ff;
      rsp_front_value = (count_ff == '0) ? '1 : chain_front;
      rsp_rear_value  = (count_ff == '0) ? '1 : chain_rear;
   end

   assign ctl.write_en   = wr_en;
   assign ctl.write_idx  = wr_idx;
   assign ctl.write_data = req_data_value;
   assign ctl.front_idx  = front_ff;
   assign ctl.rear_idx   = rear_ff;

endmodule

>>> rtl/core/circular_deque.sv
// Top level of the circular deque: the command sequencer and a row of DEPTH storage cells.
// Depends on cdq_pkg, cdq_ctrl and cdq_cell.
//
// A command is taken when start is high and busy is low. Its result appears for one cycle
// with rsp_valid high once the scan ends, and is taken at the edge that ends that cycle; a
// new command may be issued in that same result cycle, but not while busy is high. The scan
// waits on the readout chain: the front and rear values travel cell to cell through one
// register per slot before they reach the result ports. The receiver cannot stall; each
// result must be taken in its one cycle. csr_wdata sets the usable capacity (0 acts as 1,
// values above DEPTH act as DEPTH); the user must write it only while no command is in
// flight, and the block itself does not enforce this.
module circular_deque (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  cdq_pkg::cmd_type  req_command,
   input  cdq_pkg::word_type req_data_value,
   input  logic              csr_we,
   input  cdq_pkg::cnt_type  csr_wdata,
   output logic              rsp_valid,
   output logic [1:0]        rsp_status,
   output logic              rsp_is_empty,
   output cdq_pkg::cnt_type  rsp_occupancy,
   output cdq_pkg::word_type rsp_front_value,
   output cdq_pkg::word_type rsp_rear_value
);
   import cdq_pkg::*;

   cell_ctl_type ctl;
   word_type     front_chain [DEPTH+1];
   word_type     rear_chain  [DEPTH+1];

   assign front_chain[0] = '0;
   assign rear_chain[0]  = '0;

   cdq_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_command     (req_command),
      .req_data_value  (req_data_value),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .ctl             (ctl),
      .chain_front     (front_chain[DEPTH]),
      .chain_rear      (rear_chain[DEPTH]),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_occupancy   (rsp_occupancy),
      .rsp_front_value (rsp_front_value),
      .rsp_rear_value  (rsp_rear_value)
   );

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      cdq_cell u_cell (
         .clock      (clock),
         .cell_idx   (IDX_W'(i)),
         .ctl        (ctl),
         .up_front   (front_chain[i]),
         .up_rear    (rear_chain[i]),
         .down_front (front_chain[i+1]),
         .down_rear  (rear_chain[i+1])
      );
   end

endmodule

>>> rtl/core/cdq_checker.sv
// Port-level checks for circular_deque and the bind that attaches them.
// Depends on cdq_pkg and the top-level port list.
module cdq_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_valid,
   input logic [1:0]        rsp_status,
   input logic              rsp_is_empty,
   input cdq_pkg::cnt_type  rsp_occupancy,
   input cdq_pkg::word_type rsp_front_value,
   input cdq_pkg::word_type rsp_rear_value
);
   import cdq_pkg::*;

   // The empty flag and the occupancy must agree in every result.
   a_empty_matches_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_is_empty == (rsp_occupancy == '0)))
      else $error("empty flag disagrees with occupancy");

   // An empty deque reports -1 at both ends.
   a_empty_values: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_is_empty) |->
         (rsp_front_value == '1 && rsp_rear_value == '1))
      else $error("empty deque reports an element value");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == STAT_DONE || rsp_status == STAT_FULL ||
                     rsp_status == STAT_EMPTY))
      else $error("undefined status code");

   // A transfer on the command side keeps the block busy in the following cycle.
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy && !rsp_valid))
      else $error("block not busy after a command transfer");

   a_no_result_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while busy");

endmodule

bind circular_deque cdq_checker u_cdq_checker (.*);
